// ----- rtl/core/llnp_pkg.sv -----
// llnp_pkg: shared constants, operation and status codes, memory write-enable struct
// for the linked list node pool. no dependencies; used by every other file of the block.

package llnp_pkg;

  // parameter defaults
  localparam int POOL_DEPTH_DEF = 16;
  localparam int DATA_WIDTH_DEF = 32;

  // fixed port field widths
  localparam int MODE_W      = 3;
  localparam int PORT_IDX_W  = 4;
  localparam int PORT_VAL_W  = 32;
  localparam int STATUS_W    = 2;
  localparam int PORT_CNT_W  = 5;

  // operation codes; the unused codes act as a read
  localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
  localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_INS_BEFORE = 3'd2;
  localparam logic [MODE_W-1:0] MODE_INS_AFTER  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_READ       = 3'd4;

  // result status codes
  localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_NO_NODE = 2'd2;

  // per-field write enables of the node memory
  typedef struct packed {
    logic dat;
    logic nxt;
    logic prv;
  } ram_we_t;

endpackage

// ----- rtl/core/llnp_if.sv -----
// llnp_if: valid/ready channel interfaces for request and result words.
// depends on llnp_pkg for field widths.

interface llnp_in_if;
  logic                                   valid;
  logic                                   ready;
  logic        [llnp_pkg::MODE_W-1:0]     mode;
  logic        [llnp_pkg::PORT_IDX_W-1:0] target;
  logic signed [llnp_pkg::PORT_VAL_W-1:0] value;

  modport source (output valid, mode, target, value, input ready);
  modport sink   (input valid, mode, target, value, output ready);
endinterface

interface llnp_out_if;
  logic                                   valid;
  logic                                   ready;
  logic        [llnp_pkg::STATUS_W-1:0]   status;
  logic        [llnp_pkg::PORT_IDX_W-1:0] node;
  logic signed [llnp_pkg::PORT_VAL_W-1:0] node_value;
  logic        [llnp_pkg::PORT_IDX_W-1:0] next_node;
  logic                                   has_next;
  logic        [llnp_pkg::PORT_IDX_W-1:0] prev_node;
  logic                                   has_prev;
  logic        [llnp_pkg::PORT_IDX_W-1:0] first_node;
  logic        [llnp_pkg::PORT_IDX_W-1:0] last_node;
  logic        [llnp_pkg::PORT_CNT_W-1:0] node_count;

  modport source (output valid, status, node, node_value, next_node, has_next, prev_node,
                  has_prev, first_node, last_node, node_count, input ready);
  modport sink   (input valid, status, node, node_value, next_node, has_next, prev_node,
                  has_prev, first_node, last_node, node_count, output ready);
endinterface

// ----- rtl/core/llnp_node_ram.sv -----
// llnp_node_ram: node memory, one entry per pool slot holding data, next link and prev link.
// one write port with per-field enables, one registered read port. depends on llnp_pkg.

module llnp_node_ram #(
  parameter int POOL_DEPTH = llnp_pkg::POOL_DEPTH_DEF,
  parameter int DATA_WIDTH = llnp_pkg::DATA_WIDTH_DEF,
  localparam int IDX_W = $clog2(POOL_DEPTH),
  localparam int LNK_W = IDX_W + 1
) (
  input  logic                  clk,
  input  logic                  rd_en,
  input  logic [IDX_W-1:0]      rd_addr,
  output logic [DATA_WIDTH-1:0] rd_dat_r,
  output logic [LNK_W-1:0]      rd_nxt_r,
  output logic [LNK_W-1:0]      rd_prv_r,
  input  logic [IDX_W-1:0]      wr_addr,
  input  llnp_pkg::ram_we_t     wr_we,
  input  logic [DATA_WIDTH-1:0] wr_dat,
  input  logic [LNK_W-1:0]      wr_nxt,
  input  logic [LNK_W-1:0]      wr_prv
);

  // link entries are {valid, index}
  logic [DATA_WIDTH-1:0] dat_mem [POOL_DEPTH];
  logic [LNK_W-1:0]      nxt_mem [POOL_DEPTH];
  logic [LNK_W-1:0]      prv_mem [POOL_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_we.dat) begin
      dat_mem[wr_addr] <= wr_dat;
    end
    if (wr_we.nxt) begin
      nxt_mem[wr_addr] <= wr_nxt;
    end
    if (wr_we.prv) begin
      prv_mem[wr_addr] <= wr_prv;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_dat_r <= dat_mem[rd_addr];
      rd_nxt_r <= nxt_mem[rd_addr];
      rd_prv_r <= prv_mem[rd_addr];
    end
  end

endmodule

// ----- rtl/core/llnp_seq.sv -----
// llnp_seq: request sequencer; checks the request, writes the new node, patches neighbors
// and keeps head, tail and count. drives llnp_node_ram; depends on llnp_pkg.

module llnp_seq #(
  parameter int POOL_DEPTH = llnp_pkg::POOL_DEPTH_DEF,
  parameter int DATA_WIDTH = llnp_pkg::DATA_WIDTH_DEF,
  localparam int IDX_W = $clog2(POOL_DEPTH),
  localparam int CNT_W = $clog2(POOL_DEPTH + 1),
  localparam int LNK_W = IDX_W + 1
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // request word
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [llnp_pkg::MODE_W-1:0]       in_mode,
  input  logic [llnp_pkg::PORT_IDX_W-1:0]   in_target,
  input  logic [llnp_pkg::PORT_VAL_W-1:0]   in_value,
  // node memory
  output logic                              rd_en,
  output logic [IDX_W-1:0]                  rd_addr,
  input  logic [DATA_WIDTH-1:0]             rd_dat,
  input  logic [LNK_W-1:0]                  rd_nxt,
  input  logic [LNK_W-1:0]                  rd_prv,
  output logic [IDX_W-1:0]                  wr_addr,
  output llnp_pkg::ram_we_t                 wr_we,
  output logic [DATA_WIDTH-1:0]             wr_dat,
  output logic [LNK_W-1:0]                  wr_nxt,
  output logic [LNK_W-1:0]                  wr_prv,
  // result toward the output register
  input  logic                              rsp_free,
  output logic                              rsp_valid,
  output logic [llnp_pkg::STATUS_W-1:0]     rsp_status,
  output logic                              rsp_show,
  output logic [IDX_W-1:0]                  rsp_node,
  output logic [DATA_WIDTH-1:0]             rsp_dat,
  output logic [LNK_W-1:0]                  rsp_nxt,
  output logic [LNK_W-1:0]                  rsp_prv,
  output logic [IDX_W-1:0]                  rsp_head,
  output logic [IDX_W-1:0]                  rsp_tail,
  output logic [CNT_W-1:0]                  rsp_count
);

  localparam int CMP_W = (CNT_W > llnp_pkg::PORT_IDX_W) ? CNT_W : llnp_pkg::PORT_IDX_W;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_WNEW   = 5'b00010,
    S_PATCH1 = 5'b00100,
    S_PATCH2 = 5'b01000,
    S_RESP   = 5'b10000
  } state_t;

  state_t                          state_r, state_nxt;
  logic [IDX_W-1:0]                head_r, head_nxt;
  logic [IDX_W-1:0]                tail_r, tail_nxt;
  logic [CNT_W-1:0]                count_r;
  logic [llnp_pkg::MODE_W-1:0]     mode_r;
  logic [IDX_W-1:0]                tgt_r;
  logic [DATA_WIDTH-1:0]           val_r;
  logic [llnp_pkg::STATUS_W-1:0]   stat_r, stat_in;
  logic [IDX_W-1:0]                node_r;
  logic                            rd_src_r;
  logic [LNK_W-1:0]                nw_nxt_r, nw_prv_r, new_nxt, new_prv;
  logic [IDX_W-1:0]                pa_r, pb_r, pa_nxt, pb_nxt;
  logic                            pa_prv_r, pa_en_r, pb_en_r;
  logic                            pa_prv_nxt, pa_en_nxt, pb_en_nxt;

  logic                            accept, is_read, is_ins, tgt_bad, cnt_full, count_nz;
  logic [CMP_W+llnp_pkg::PORT_IDX_W-1:0] tgt_wide;
  logic [CMP_W+CNT_W-1:0]          cnt_wide;
  logic [CMP_W-1:0]                tgt_ext, cnt_ext;
  logic [DATA_WIDTH+llnp_pkg::PORT_VAL_W-1:0] val_wide;
  logic [LNK_W-1:0]                node_lnk;

  // request decode
  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);
  assign is_read  = !(in_mode inside {llnp_pkg::MODE_PUSH_FRONT, llnp_pkg::MODE_PUSH_BACK,
                                      llnp_pkg::MODE_INS_BEFORE, llnp_pkg::MODE_INS_AFTER});
  assign is_ins   = in_mode inside {llnp_pkg::MODE_INS_BEFORE, llnp_pkg::MODE_INS_AFTER};
  assign tgt_wide = {{CMP_W{1'b0}}, in_target};
  assign cnt_wide = {{CMP_W{1'b0}}, count_r};
  assign tgt_ext  = tgt_wide[CMP_W-1:0];
  assign cnt_ext  = cnt_wide[CMP_W-1:0];
  assign tgt_bad  = (tgt_ext >= cnt_ext);
  assign cnt_full = (count_r == CNT_W'(POOL_DEPTH));
  assign count_nz = (count_r != '0);
  assign val_wide = {{DATA_WIDTH{1'b0}}, in_value};
  assign node_lnk = {1'b1, node_r};

  always_comb begin
    if ((is_read || is_ins) && tgt_bad) begin
      stat_in = llnp_pkg::STAT_NO_NODE;
    end else if (!is_read && cnt_full) begin
      stat_in = llnp_pkg::STAT_FULL;
    end else begin
      stat_in = llnp_pkg::STAT_OK;
    end
  end

  // target entry is read as the request is taken; the data sits in the ram output
  // register until the next request, so it serves both reads and inserts
  assign rd_en   = accept;
  assign rd_addr = tgt_ext[IDX_W-1:0];

  // new node links and neighbor patch plan
  always_comb begin
    new_nxt    = '0;
    new_prv    = '0;
    pa_nxt     = tgt_r;
    pa_prv_nxt = 1'b0;
    pa_en_nxt  = 1'b0;
    pb_nxt     = tgt_r;
    pb_en_nxt  = 1'b0;
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    case (mode_r)
      llnp_pkg::MODE_PUSH_FRONT: begin
        new_nxt    = {count_nz, head_r};
        pa_nxt     = head_r;
        pa_prv_nxt = 1'b1;
        pa_en_nxt  = count_nz;
        head_nxt   = node_r;
        if (!count_nz) begin
          tail_nxt = node_r;
        end
      end
      llnp_pkg::MODE_PUSH_BACK: begin
        new_prv    = {count_nz, tail_r};
        pa_nxt     = tail_r;
        pa_en_nxt  = count_nz;
        tail_nxt   = node_r;
        if (!count_nz) begin
          head_nxt = node_r;
        end
      end
      llnp_pkg::MODE_INS_BEFORE: begin
        new_nxt    = {1'b1, tgt_r};
        new_prv    = rd_prv;
        pa_prv_nxt = 1'b1;
        pa_en_nxt  = 1'b1;
        pb_nxt     = rd_prv[IDX_W-1:0];
        pb_en_nxt  = rd_prv[IDX_W];
        if (!rd_prv[IDX_W]) begin
          head_nxt = node_r;
        end
      end
      llnp_pkg::MODE_INS_AFTER: begin
        new_nxt    = rd_nxt;
        new_prv    = {1'b1, tgt_r};
        pa_en_nxt  = 1'b1;
        pb_nxt     = rd_nxt[IDX_W-1:0];
        pb_en_nxt  = rd_nxt[IDX_W];
        if (!rd_nxt[IDX_W]) begin
          tail_nxt = node_r;
        end
      end
      default: begin
      end
    endcase
  end

  // memory write port
  always_comb begin
    wr_addr = node_r;
    wr_we   = '0;
    wr_dat  = val_r;
    wr_nxt  = node_lnk;
    wr_prv  = node_lnk;
    case (state_r)
      S_WNEW: begin
        wr_we  = '{dat: 1'b1, nxt: 1'b1, prv: 1'b1};
        wr_nxt = new_nxt;
        wr_prv = new_prv;
      end
      S_PATCH1: begin
        wr_addr    = pa_r;
        wr_we.nxt  = pa_en_r && !pa_prv_r;
        wr_we.prv  = pa_en_r && pa_prv_r;
      end
      S_PATCH2: begin
        wr_addr    = pb_r;
        wr_we.nxt  = pa_prv_r;
        wr_we.prv  = !pa_prv_r;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = (stat_in == llnp_pkg::STAT_OK && !is_read) ? S_WNEW : S_RESP;
        end
      end
      S_WNEW:   state_nxt = S_PATCH1;
      S_PATCH1: state_nxt = pb_en_r ? S_PATCH2 : S_RESP;
      S_PATCH2: state_nxt = S_RESP;
      S_RESP: begin
        if (rsp_free) begin
          state_nxt = S_IDLE;
        end
      end
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_WNEW) begin
        head_r  <= head_nxt;
        tail_r  <= tail_nxt;
        count_r <= count_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r   <= in_mode;
      tgt_r    <= tgt_ext[IDX_W-1:0];
      val_r    <= val_wide[DATA_WIDTH-1:0];
      stat_r   <= stat_in;
      node_r   <= is_read ? tgt_ext[IDX_W-1:0] : count_r[IDX_W-1:0];
      rd_src_r <= is_read;
    end
    if (state_r == S_WNEW) begin
      nw_nxt_r <= new_nxt;
      nw_prv_r <= new_prv;
      pa_r     <= pa_nxt;
      pa_prv_r <= pa_prv_nxt;
      pa_en_r  <= pa_en_nxt;
      pb_r     <= pb_nxt;
      pb_en_r  <= pb_en_nxt;
    end
  end

  // result
  assign rsp_valid  = (state_r == S_RESP) && rsp_free;
  assign rsp_status = stat_r;
  assign rsp_show   = (stat_r == llnp_pkg::STAT_OK);
  assign rsp_node   = node_r;
  assign rsp_dat    = rd_src_r ? rd_dat : val_r;
  assign rsp_nxt    = rd_src_r ? rd_nxt : nw_nxt_r;
  assign rsp_prv    = rd_src_r ? rd_prv : nw_prv_r;
  assign rsp_head   = head_r;
  assign rsp_tail   = tail_r;
  assign rsp_count  = count_r;

  // checks
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WNEW) |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("count did not step on node write");

  a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_WNEW) |=> $stable(count_r))
    else $error("count changed outside node write");

  a_write_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WNEW) |-> (stat_r == llnp_pkg::STAT_OK))
    else $error("failed request reached the memory");

  a_patch_addr: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_PATCH1 || state_r == S_PATCH2) && (wr_we.nxt || wr_we.prv))
      |-> (wr_addr != node_r))
    else $error("neighbor patch hit the new node");

  a_ends_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != '0) |-> (CNT_W'(head_r) < count_r && CNT_W'(tail_r) < count_r))
    else $error("head or tail names an unallocated node");

endmodule

// ----- rtl/core/linked_list_node_pool.sv -----
// linked_list_node_pool: top level of the insert-only doubly linked list in a node pool.
// depends on llnp_pkg, llnp_if, llnp_node_ram and llnp_seq.
//
//   channel    role     handshake            word
//   in_chan    sink     valid/ready          mode, target, value
//   out_chan   source   valid/ready          status, node, node_value, links, head, tail, count
//
// a read or a failed request goes straight to the result step; a push writes the new node and
// then patches the old end if there is one; an insert writes the new node, patches the target
// and relinks the neighbor on the far side if there is one. the node memory has one write port,
// so these writes come in turn; the target entry is read in the cycle the request is taken.
// reset clears head, tail, count and the handshake state; node memory stays undefined
// and needs no clearing pass, since only allocated entries are ever reported or linked.
// a result waits in the output register while out_chan.ready is low; the next request
// is still taken and worked, and only its result step holds until the register drains.

module linked_list_node_pool #(
  parameter int POOL_DEPTH = llnp_pkg::POOL_DEPTH_DEF,
  parameter int DATA_WIDTH = llnp_pkg::DATA_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  llnp_in_if.sink    in_chan,
  llnp_out_if.source out_chan
);

  localparam int IDX_W = $clog2(POOL_DEPTH);
  localparam int CNT_W = $clog2(POOL_DEPTH + 1);
  localparam int LNK_W = IDX_W + 1;
  localparam int PIW   = llnp_pkg::PORT_IDX_W;
  localparam int PVW   = llnp_pkg::PORT_VAL_W;
  localparam int PCW   = llnp_pkg::PORT_CNT_W;

  // memory port wires
  logic                  rd_en;
  logic [IDX_W-1:0]      rd_addr;
  logic [DATA_WIDTH-1:0] rd_dat;
  logic [LNK_W-1:0]      rd_nxt, rd_prv;
  logic [IDX_W-1:0]      wr_addr;
  llnp_pkg::ram_we_t     wr_we;
  logic [DATA_WIDTH-1:0] wr_dat;
  logic [LNK_W-1:0]      wr_nxt, wr_prv;

  // result from the sequencer
  logic                           rsp_free, rsp_valid, rsp_show;
  logic [llnp_pkg::STATUS_W-1:0]  rsp_status;
  logic [IDX_W-1:0]               rsp_node, rsp_head, rsp_tail;
  logic [DATA_WIDTH-1:0]          rsp_dat;
  logic [LNK_W-1:0]               rsp_nxt, rsp_prv;
  logic [CNT_W-1:0]               rsp_count;

  // output register
  logic                           out_valid_r;
  logic [llnp_pkg::STATUS_W-1:0]  out_status_r;
  logic [PIW-1:0]                 out_node_r, out_next_r, out_prev_r, out_first_r, out_last_r;
  logic [PVW-1:0]                 out_value_r;
  logic                           out_has_next_r, out_has_prev_r;
  logic [PCW-1:0]                 out_count_r;

  // port width conversion: zero-extend, then keep the low bits
  function automatic logic [PIW-1:0] idx_out(input logic [IDX_W-1:0] idx);
    logic [IDX_W+PIW-1:0] wide;
    wide = {{PIW{1'b0}}, idx};
    return wide[PIW-1:0];
  endfunction

  function automatic logic [PVW-1:0] dat_out(input logic [DATA_WIDTH-1:0] dat);
    logic [DATA_WIDTH+PVW-1:0] wide;
    wide = {{PVW{1'b0}}, dat};
    return wide[PVW-1:0];
  endfunction

  function automatic logic [PCW-1:0] cnt_out(input logic [CNT_W-1:0] cnt);
    logic [CNT_W+PCW-1:0] wide;
    wide = {{PCW{1'b0}}, cnt};
    return wide[PCW-1:0];
  endfunction

  llnp_node_ram #(
    .POOL_DEPTH (POOL_DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ram (
    .clk      (clk),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_dat_r (rd_dat),
    .rd_nxt_r (rd_nxt),
    .rd_prv_r (rd_prv),
    .wr_addr  (wr_addr),
    .wr_we    (wr_we),
    .wr_dat   (wr_dat),
    .wr_nxt   (wr_nxt),
    .wr_prv   (wr_prv)
  );

  llnp_seq #(
    .POOL_DEPTH (POOL_DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_chan.valid),
    .in_ready   (in_chan.ready),
    .in_mode    (in_chan.mode),
    .in_target  (in_chan.target),
    .in_value   (in_chan.value),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_dat     (rd_dat),
    .rd_nxt     (rd_nxt),
    .rd_prv     (rd_prv),
    .wr_addr    (wr_addr),
    .wr_we      (wr_we),
    .wr_dat     (wr_dat),
    .wr_nxt     (wr_nxt),
    .wr_prv     (wr_prv),
    .rsp_free   (rsp_free),
    .rsp_valid  (rsp_valid),
    .rsp_status (rsp_status),
    .rsp_show   (rsp_show),
    .rsp_node   (rsp_node),
    .rsp_dat    (rsp_dat),
    .rsp_nxt    (rsp_nxt),
    .rsp_prv    (rsp_prv),
    .rsp_head   (rsp_head),
    .rsp_tail   (rsp_tail),
    .rsp_count  (rsp_count)
  );

  // the register can take a new word when empty or when its word leaves this cycle
  assign rsp_free = !out_valid_r || out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rsp_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_valid) begin
      out_status_r <= rsp_status;
      // failed requests report zeros for the node fields
      if (rsp_show) begin
        out_node_r     <= idx_out(rsp_node);
        out_value_r    <= dat_out(rsp_dat);
        out_next_r     <= rsp_nxt[IDX_W] ? idx_out(rsp_nxt[IDX_W-1:0]) : '0;
        out_has_next_r <= rsp_nxt[IDX_W];
        out_prev_r     <= rsp_prv[IDX_W] ? idx_out(rsp_prv[IDX_W-1:0]) : '0;
        out_has_prev_r <= rsp_prv[IDX_W];
      end else begin
        out_node_r     <= '0;
        out_value_r    <= '0;
        out_next_r     <= '0;
        out_has_next_r <= 1'b0;
        out_prev_r     <= '0;
        out_has_prev_r <= 1'b0;
      end
      // empty list shows zero ends
      out_first_r <= (rsp_count != '0) ? idx_out(rsp_head) : '0;
      out_last_r  <= (rsp_count != '0) ? idx_out(rsp_tail) : '0;
      out_count_r <= cnt_out(rsp_count);
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.status     = out_status_r;
  assign out_chan.node       = out_node_r;
  assign out_chan.node_value = out_value_r;
  assign out_chan.next_node  = out_next_r;
  assign out_chan.has_next   = out_has_next_r;
  assign out_chan.prev_node  = out_prev_r;
  assign out_chan.has_prev   = out_has_prev_r;
  assign out_chan.first_node = out_first_r;
  assign out_chan.last_node  = out_last_r;
  assign out_chan.node_count = out_count_r;

endmodule
